// File: sv/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg: shared definitions for the 3x3 median filter
// Sizes, register indexes and the result record carried through the queue.
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int CNT_W      = 23;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_W      = 13;

  // Result queue: up to three results enter per cycle, one leaves.
  localparam int RES_DEPTH  = 8;
  localparam int RES_PTR_W  = 3;
  localparam int RES_CNT_W  = 4;
  localparam int RES_SLOTS  = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [8:0] win9_t;

  typedef enum logic {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    pix_t             pixel;
    logic             changed;
    logic [CNT_W-1:0] total;
    logic             last;
    logic             done;
  } res_t;

endpackage

// File: sv/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram: generic simple dual-port RAM
// One write port and one read port with a registered, read-first output.
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: sv/mf3_median9.sv
// ----------------------------------------------------------------------------
// mf3_median9: median of nine pixels
// Fixed compare-exchange network of nineteen exchanges; the median settles
// in the middle element.
// ----------------------------------------------------------------------------
module mf3_median9 (
  input  mf3_pkg::win9_t win,
  output mf3_pkg::pix_t  med
);

  function automatic mf3_pkg::pix_t mn(mf3_pkg::pix_t a, mf3_pkg::pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic mf3_pkg::pix_t mx(mf3_pkg::pix_t a, mf3_pkg::pix_t b);
    return (a < b) ? b : a;
  endfunction

  mf3_pkg::win9_t p;

  always_comb begin
    p = win;
    {p[1], p[2]} = {mn(p[1], p[2]), mx(p[1], p[2])};
    {p[4], p[5]} = {mn(p[4], p[5]), mx(p[4], p[5])};
    {p[7], p[8]} = {mn(p[7], p[8]), mx(p[7], p[8])};
    {p[0], p[1]} = {mn(p[0], p[1]), mx(p[0], p[1])};
    {p[3], p[4]} = {mn(p[3], p[4]), mx(p[3], p[4])};
    {p[6], p[7]} = {mn(p[6], p[7]), mx(p[6], p[7])};
    {p[1], p[2]} = {mn(p[1], p[2]), mx(p[1], p[2])};
    {p[4], p[5]} = {mn(p[4], p[5]), mx(p[4], p[5])};
    {p[7], p[8]} = {mn(p[7], p[8]), mx(p[7], p[8])};
    {p[0], p[3]} = {mn(p[0], p[3]), mx(p[0], p[3])};
    {p[5], p[8]} = {mn(p[5], p[8]), mx(p[5], p[8])};
    {p[4], p[7]} = {mn(p[4], p[7]), mx(p[4], p[7])};
    {p[3], p[6]} = {mn(p[3], p[6]), mx(p[3], p[6])};
    {p[1], p[4]} = {mn(p[1], p[4]), mx(p[1], p[4])};
    {p[2], p[5]} = {mn(p[2], p[5]), mx(p[2], p[5])};
    {p[4], p[7]} = {mn(p[4], p[7]), mx(p[4], p[7])};
    {p[4], p[2]} = {mn(p[4], p[2]), mx(p[4], p[2])};
    {p[6], p[4]} = {mn(p[6], p[4]), mx(p[6], p[4])};
    {p[4], p[2]} = {mn(p[4], p[2]), mx(p[4], p[2])};
  end

  assign med = p[4];

endmodule

// File: sv/median_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_unit: streaming 3x3 median filter
// Pixels arrive in raster order on the input channel, one item each. Interior
// pixels leave as the median of their neighborhood, border pixels unchanged.
// Row r-1 of the interior is emitted while row r arrives; the first and last
// rows leave as they arrive. Each input item causes zero to three results.
// The frame size is set through the cfg_ write port (index 0 width, index 1
// height) while the filter is idle; reset selects 1024 x 1024.
// An accepted item is looked up in the two line RAMs in its accept cycle, is
// filtered in the next cycle and its results enter an eight-entry result
// queue, whose head drives the output directly.
// One pixel per cycle is taken while the queue has room for three more
// results; in_ready depends only on registers. Inside a frame most pixels
// cause one result, the last row two, so in the last row the single output
// port bounds the pixel rate. A stalled receiver fills the queue and then
// holds in_ready low; nothing is lost.
// Reset clears positions, window, change count and queue; the line RAMs are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [mf3_pkg::PIX_W-1:0]   in_pixel_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mf3_pkg::ROW_W-1:0]   out_row,
  output logic [mf3_pkg::COL_W-1:0]   out_column,
  output logic [mf3_pkg::PIX_W-1:0]   out_pixel_out,
  output logic                        out_changed,
  output logic [mf3_pkg::CNT_W-1:0]   out_changed_total,
  output logic                        out_last_of_run,
  output logic                        out_frame_done,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [mf3_pkg::CFG_W-1:0]   cfg_wdata
);

  // Configuration.
  logic [mf3_pkg::FW_W-1:0]  frame_width_r;
  logic [mf3_pkg::FH_W-1:0]  frame_height_r;
  logic [mf3_pkg::COL_W-1:0] wm1;
  logic [mf3_pkg::ROW_W-1:0] hm1;

  // Position and accept stage.
  logic [mf3_pkg::COL_W-1:0] col_r, col_nxt, c_eff;
  logic [mf3_pkg::ROW_W-1:0] row_r, row_nxt, r_eff;
  logic                      accept;

  // Filter stage.
  logic                      s1_valid_r;
  mf3_pkg::pix_t             s1_pix_r;
  logic [mf3_pkg::COL_W-1:0] s1_col_r;
  logic [mf3_pkg::ROW_W-1:0] s1_row_r;
  logic                      s1_r_ge2_r, s1_c_ge2_r, s1_c_eq1_r;
  logic                      s1_last_col_r, s1_edge_row_r, s1_end_r;
  logic                      s1_fwd_r;
  mf3_pkg::pix_t             s1_fwd_up_r, s1_fwd_mid_r;
  mf3_pkg::pix_t             up_rdata, mid_rdata, up, mid;
  mf3_pkg::pix_t             win_r [6];
  mf3_pkg::win9_t            win9;
  mf3_pkg::pix_t             med;
  logic [mf3_pkg::CNT_W-1:0] chg_cnt_r, chg_cnt_inc, chg_cnt_nxt;

  // Result queue.
  mf3_pkg::res_t             cand [mf3_pkg::RES_SLOTS];
  logic [mf3_pkg::RES_SLOTS-1:0] cand_v;
  logic [mf3_pkg::RES_PTR_W-1:0] widx [mf3_pkg::RES_SLOTS];
  logic [1:0]                push_n;
  logic                      pop;
  mf3_pkg::res_t             res_q_r [mf3_pkg::RES_DEPTH];
  logic [mf3_pkg::RES_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [mf3_pkg::RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= mf3_pkg::FW_W'(mf3_pkg::MAX_WIDTH);
      frame_height_r <= mf3_pkg::FH_W'(1024);
    end else if (cfg_we) begin
      if (cfg_index == mf3_pkg::CFG_FRAME_WIDTH) begin
        frame_width_r <= cfg_wdata[mf3_pkg::FW_W-1:0];
      end else begin
        frame_height_r <= cfg_wdata;
      end
    end
  end

  // Zero acts as one and oversize acts as the maximum.
  always_comb begin
    if (frame_width_r == '0) begin
      wm1 = '0;
    end else if (frame_width_r > mf3_pkg::FW_W'(mf3_pkg::MAX_WIDTH)) begin
      wm1 = mf3_pkg::COL_W'(mf3_pkg::MAX_WIDTH - 1);
    end else begin
      wm1 = mf3_pkg::COL_W'(frame_width_r - 1'b1);
    end
    if (frame_height_r == '0) begin
      hm1 = '0;
    end else if (frame_height_r > mf3_pkg::FH_W'(mf3_pkg::MAX_HEIGHT)) begin
      hm1 = mf3_pkg::ROW_W'(mf3_pkg::MAX_HEIGHT - 1);
    end else begin
      hm1 = mf3_pkg::ROW_W'(frame_height_r - 1'b1);
    end
  end

  assign c_eff  = (col_r > wm1) ? wm1 : col_r;
  assign r_eff  = (row_r > hm1) ? hm1 : row_r;
  assign accept = in_valid && in_ready;

  always_comb begin
    if (c_eff >= wm1) begin
      col_nxt = '0;
      row_nxt = (r_eff >= hm1) ? '0 : r_eff + 1'b1;
    end else begin
      col_nxt = c_eff + 1'b1;
      row_nxt = r_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // A one-column frame reads the column the filter stage is writing in the
  // same cycle; the RAM returns the old entry, so the new one is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r      <= in_pixel_in;
      s1_col_r      <= c_eff;
      s1_row_r      <= r_eff;
      s1_r_ge2_r    <= (r_eff >= mf3_pkg::ROW_W'(2));
      s1_c_ge2_r    <= (c_eff >= mf3_pkg::COL_W'(2));
      s1_c_eq1_r    <= (c_eff == mf3_pkg::COL_W'(1));
      s1_last_col_r <= (c_eff == wm1);
      s1_edge_row_r <= (r_eff == '0) || (r_eff == hm1);
      s1_end_r      <= (c_eff == wm1) && (r_eff == hm1);
      s1_fwd_r      <= s1_valid_r && (s1_col_r == c_eff);
      s1_fwd_up_r   <= mid;
      s1_fwd_mid_r  <= s1_pix_r;
    end
  end

  mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(mf3_pkg::MAX_WIDTH)) u_line_upper (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (mid),
    .re    (accept),
    .raddr (c_eff),
    .rdata (up_rdata)
  );

  mf3_ram #(.WIDTH(mf3_pkg::PIX_W), .DEPTH(mf3_pkg::MAX_WIDTH)) u_line_middle (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_col_r),
    .wdata (s1_pix_r),
    .re    (accept),
    .raddr (c_eff),
    .rdata (mid_rdata)
  );

  assign up  = s1_fwd_r ? s1_fwd_up_r  : up_rdata;
  assign mid = s1_fwd_r ? s1_fwd_mid_r : mid_rdata;

  always_comb begin
    win9[0] = win_r[0];
    win9[1] = win_r[1];
    win9[2] = up;
    win9[3] = win_r[2];
    win9[4] = win_r[3];
    win9[5] = mid;
    win9[6] = win_r[4];
    win9[7] = win_r[5];
    win9[8] = s1_pix_r;
  end

  mf3_median9 u_median (
    .win (win9),
    .med (med)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
      chg_cnt_r <= '0;
    end else if (s1_valid_r) begin
      win_r[0]  <= win_r[1];
      win_r[1]  <= up;
      win_r[2]  <= win_r[3];
      win_r[3]  <= mid;
      win_r[4]  <= win_r[5];
      win_r[5]  <= s1_pix_r;
      chg_cnt_r <= chg_cnt_nxt;
    end
  end

  // Candidate results in output order: the pixel left of this column in the
  // row above, the last pixel of the row above, then this pixel itself.
  always_comb begin
    cand_v[0] = s1_r_ge2_r && (s1_c_ge2_r || s1_c_eq1_r);
    cand_v[1] = s1_r_ge2_r && s1_last_col_r;
    cand_v[2] = s1_edge_row_r;

    cand[0].row     = s1_row_r - 1'b1;
    cand[0].column  = s1_c_ge2_r ? s1_col_r - 1'b1 : '0;
    cand[0].pixel   = s1_c_ge2_r ? med : win_r[3];
    cand[0].changed = s1_c_ge2_r && (med != win_r[3]);

    cand[1].row     = s1_row_r - 1'b1;
    cand[1].column  = s1_col_r;
    cand[1].pixel   = mid;
    cand[1].changed = 1'b0;

    cand[2].row     = s1_row_r;
    cand[2].column  = s1_col_r;
    cand[2].pixel   = s1_pix_r;
    cand[2].changed = 1'b0;

    if (cand_v[0] && cand[0].changed && (chg_cnt_r != mf3_pkg::CNT_MAX)) begin
      chg_cnt_inc = chg_cnt_r + 1'b1;
    end else begin
      chg_cnt_inc = chg_cnt_r;
    end
    chg_cnt_nxt = s1_end_r ? '0 : chg_cnt_inc;

    cand[0].last = cand_v[0] && !cand_v[1] && !cand_v[2];
    cand[1].last = cand_v[1] && !cand_v[2];
    cand[2].last = cand_v[2];
    for (int k = 0; k < mf3_pkg::RES_SLOTS; k++) begin
      cand[k].total = chg_cnt_inc;
      cand[k].done  = cand[k].last && s1_end_r;
    end

    widx[0] = wr_ptr_r;
    widx[1] = wr_ptr_r + mf3_pkg::RES_PTR_W'(cand_v[0]);
    widx[2] = widx[1] + mf3_pkg::RES_PTR_W'(cand_v[1]);
    push_n  = s1_valid_r ? 2'(cand_v[0]) + 2'(cand_v[1]) + 2'(cand_v[2]) : 2'd0;
  end

  assign out_valid   = (res_cnt_r != '0);
  assign pop         = out_valid && out_ready;
  assign res_cnt_nxt = res_cnt_r + mf3_pkg::RES_CNT_W'(push_n)
                       - mf3_pkg::RES_CNT_W'(pop);
  // Room for the results of the item in the filter stage plus three more.
  assign in_ready    = (res_cnt_r + mf3_pkg::RES_CNT_W'(push_n))
                       <= mf3_pkg::RES_CNT_W'(mf3_pkg::RES_DEPTH - mf3_pkg::RES_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      res_cnt_r <= '0;
    end else begin
      wr_ptr_r  <= wr_ptr_r + mf3_pkg::RES_PTR_W'(push_n);
      rd_ptr_r  <= rd_ptr_r + mf3_pkg::RES_PTR_W'(pop);
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < mf3_pkg::RES_SLOTS; k++) begin
      if (s1_valid_r && cand_v[k]) begin
        res_q_r[widx[k]] <= cand[k];
      end
    end
  end

  assign out_row           = res_q_r[rd_ptr_r].row;
  assign out_column        = res_q_r[rd_ptr_r].column;
  assign out_pixel_out     = res_q_r[rd_ptr_r].pixel;
  assign out_changed       = res_q_r[rd_ptr_r].changed;
  assign out_changed_total = res_q_r[rd_ptr_r].total;
  assign out_last_of_run   = res_q_r[rd_ptr_r].last;
  assign out_frame_done    = res_q_r[rd_ptr_r].done;

  // The queue never overflows.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= mf3_pkg::RES_CNT_W'(mf3_pkg::RES_DEPTH))
    else $error("result queue overflow");

  // An accepted item always finds room for its results in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (res_cnt_r + 4'(push_n) <= mf3_pkg::RES_CNT_W'(mf3_pkg::RES_DEPTH)))
    else $error("results of an item do not fit in the queue");

  // The final result of a frame also closes its item.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> out_last_of_run)
    else $error("frame done without last of run");

  // After the last pixel of a frame the position wraps to the origin.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (c_eff == wm1) && (r_eff == hm1)) |=> (col_r == '0 && row_r == '0))
    else $error("position did not wrap at end of frame");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the streaming 3x3 median filter
// Frames of many sizes go through the filter, with random gaps on the pixel
// side and random stalls on the result side. A scoreboard predicts each
// result from its own line stores and window. Results are compared field by
// field in arrival order.
// ----------------------------------------------------------------------------

class median_scoreboard;
  int unsigned width_reg;
  int unsigned height_reg;
  mf3_pkg::pix_t upper_line [mf3_pkg::MAX_WIDTH];
  mf3_pkg::pix_t middle_line [mf3_pkg::MAX_WIDTH];
  mf3_pkg::pix_t win_cols [6];
  int unsigned row_at;
  int unsigned col_at;
  logic [mf3_pkg::CNT_W-1:0] changed_seen;
  mf3_pkg::res_t pending [$];
  int errors;

  function new();
    width_reg = 1024;
    height_reg = 1024;
    foreach (upper_line[i]) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    foreach (win_cols[i]) win_cols[i] = '0;
    row_at = 0;
    col_at = 0;
    changed_seen = '0;
    errors = 0;
  endfunction

  function void write_reg(mf3_pkg::cfg_idx_t idx, int unsigned value);
    if (idx == mf3_pkg::CFG_FRAME_WIDTH) width_reg = value & 'h7FF;
    else height_reg = value & 'h1FFF;
  endfunction

  function void add_result(int unsigned row, int unsigned col, mf3_pkg::pix_t pix,
                           bit chg);
    mf3_pkg::res_t res;
    if (chg && changed_seen != mf3_pkg::CNT_MAX) changed_seen = changed_seen + 1'b1;
    res.row = row[mf3_pkg::ROW_W-1:0];
    res.column = col[mf3_pkg::COL_W-1:0];
    res.pixel = pix;
    res.changed = chg;
    res.total = changed_seen;
    res.last = 1'b0;
    res.done = 1'b0;
    pending.push_back(res);
  endfunction

  // Works out the results caused by one accepted pixel.
  function void note_pixel(mf3_pkg::pix_t p);
    int unsigned w, h, c, r;
    int n0, i, j;
    mf3_pkg::pix_t up, mid, x;
    mf3_pkg::pix_t v [9];
    mf3_pkg::res_t tail;
    bit frame_end;
    w = width_reg;
    h = height_reg;
    if (w == 0) w = 1;
    if (w > mf3_pkg::MAX_WIDTH) w = mf3_pkg::MAX_WIDTH;
    if (h == 0) h = 1;
    if (h > mf3_pkg::MAX_HEIGHT) h = mf3_pkg::MAX_HEIGHT;
    // A position left beyond a bound that shrank acts as the last one.
    c = (col_at > w - 1) ? w - 1 : col_at;
    r = (row_at > h - 1) ? h - 1 : row_at;
    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = p;
    n0 = pending.size();
    if (r >= 2) begin
      if (c >= 2) begin
        v = '{win_cols[0], win_cols[1], up, win_cols[2], win_cols[3], mid,
              win_cols[4], win_cols[5], p};
        for (i = 1; i < 9; i++) begin
          x = v[i];
          j = i;
          while (j > 0 && v[j-1] > x) begin
            v[j] = v[j-1];
            j--;
          end
          v[j] = x;
        end
        add_result(r - 1, c - 1, v[4], v[4] != win_cols[3]);
      end else if (c == 1) begin
        add_result(r - 1, 0, win_cols[3], 1'b0);
      end
      if (c == w - 1) add_result(r - 1, c, mid, 1'b0);
    end
    if (r == 0 || r == h - 1) add_result(r, c, p, 1'b0);
    win_cols[0] = win_cols[1];
    win_cols[1] = up;
    win_cols[2] = win_cols[3];
    win_cols[3] = mid;
    win_cols[4] = win_cols[5];
    win_cols[5] = p;
    frame_end = (r == h - 1) && (c == w - 1);
    if (pending.size() > n0) begin
      tail = pending.pop_back();
      tail.last = 1'b1;
      tail.done = frame_end;
      pending.push_back(tail);
    end
    if (c == w - 1) begin
      c = 0;
      r = (r == h - 1) ? 0 : r + 1;
    end else begin
      c++;
    end
    col_at = c;
    row_at = r;
    if (frame_end) changed_seen = '0;
  endfunction

  function void compare(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  function void check_result(mf3_pkg::res_t got);
    mf3_pkg::res_t want;
    if (pending.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, got row %0d column %0d pixel %0d",
               $time, got.row, got.column, got.pixel);
      return;
    end
    want = pending.pop_front();
    compare("row", want.row, got.row);
    compare("column", want.column, got.column);
    compare("pixel", want.pixel, got.pixel);
    compare("changed", want.changed, got.changed);
    compare("changed_total", want.total, got.total);
    compare("last_of_run", want.last, got.last);
    compare("frame_done", want.done, got.done);
  endfunction
endclass

module tb;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  mf3_pkg::pix_t                  in_pixel_in;
  logic                           out_valid;
  logic                           out_ready;
  logic [mf3_pkg::ROW_W-1:0]      out_row;
  logic [mf3_pkg::COL_W-1:0]      out_column;
  mf3_pkg::pix_t                  out_pixel_out;
  logic                           out_changed;
  logic [mf3_pkg::CNT_W-1:0]      out_changed_total;
  logic                           out_last_of_run;
  logic                           out_frame_done;
  logic                           cfg_we;
  mf3_pkg::cfg_idx_t              cfg_index;
  logic [mf3_pkg::CFG_W-1:0]      cfg_wdata;

  median_scoreboard sb;
  mf3_pkg::res_t result_seen;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_left = 0;
  mf3_pkg::pix_t pix_base = '0;

  median_filter_3x3_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      result_seen.row = out_row;
      result_seen.column = out_column;
      result_seen.pixel = out_pixel_out;
      result_seen.changed = out_changed;
      result_seen.total = out_changed_total;
      result_seen.last = out_last_of_run;
      result_seen.done = out_frame_done;
      sb.check_result(result_seen);
    end
  end

  // Result side: a requested hold-off first, random stalls otherwise.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mix of noise, impulses and near-flat areas, so medians both change
  // and keep the center pixel.
  function automatic mf3_pkg::pix_t next_pixel();
    case ($urandom_range(3))
      0: return mf3_pkg::pix_t'($urandom_range(255));
      1: return ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
      default: return pix_base ^ mf3_pkg::pix_t'($urandom_range(3));
    endcase
  endfunction

  task automatic set_pace(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high.
  task automatic send_pixel(input mf3_pkg::pix_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_pixel_in = p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_pixel(p);
    @(negedge clk);
  endtask

  // Sends pixels until the frame in progress is complete.
  task automatic send_frame(output int count);
    pix_base = mf3_pkg::pix_t'($urandom_range(255));
    count = 0;
    do begin
      send_pixel(next_pixel());
      count++;
    end while (sb.row_at != 0 || sb.col_at != 0);
  endtask

  // Waits until every predicted result has arrived. Pixels of an interior
  // row may cause no result, so it then waits on while the pipeline empties.
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    drain();
    cfg_we = 1'b1;
    cfg_index = mf3_pkg::CFG_FRAME_WIDTH;
    cfg_wdata = w[mf3_pkg::CFG_W-1:0];
    sb.write_reg(mf3_pkg::CFG_FRAME_WIDTH, w);
    @(negedge clk);
    cfg_index = mf3_pkg::CFG_FRAME_HEIGHT;
    cfg_wdata = h[mf3_pkg::CFG_W-1:0];
    sb.write_reg(mf3_pkg::CFG_FRAME_HEIGHT, h);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    int count;
    int rnd_items;
    int frame_no;
    int w;
    int h;
    mf3_pkg::pix_t square [9];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_in = '0;
    cfg_we = 1'b0;
    cfg_index = mf3_pkg::CFG_FRAME_WIDTH;
    cfg_wdata = '0;
    sb = new();
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Zero sizes act as one: two single-pixel frames at the pixel extremes.
    set_pace(0, 0);
    set_frame(0, 0);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    // A lone bright impulse in a 3x3 frame is removed by the median.
    set_frame(3, 3);
    square = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
    foreach (square[i]) send_pixel(square[i]);
    // Narrow frames have no interior, so every pixel passes through.
    set_frame(2, 4);
    send_frame(count);
    set_frame(4, 1);
    send_frame(count);
    // A one-column frame reads back the line entry that the item before it
    // has just written.
    set_frame(1, 6);
    send_frame(count);

    // Oversized sizes act as the maximum. Part of the first row goes through,
    // then a small size ends the frame from a column past the new width.
    set_pace(13, 13);
    set_frame(2047, 8191);
    repeat (6) send_pixel(next_pixel());
    set_frame(4, 3);
    send_frame(count);
    // The receiver holds off at first, so the result queue fills and the
    // input side has to stall.
    set_pace(0, 65);
    set_frame(6, 4);
    hold_left = 60;
    send_frame(count);

    // Size changes in the middle of a frame.
    set_pace(0, 0);
    set_frame(8, 6);
    repeat (20) send_pixel(next_pixel());
    // The current column now lies past the new width and acts as the last one.
    set_frame(3, 6);
    repeat (5) send_pixel(next_pixel());
    // The current row now lies past the new height and acts as the last one.
    set_frame(3, 3);
    send_frame(count);

    rnd_items = 0;
    frame_no = 0;
    while (rnd_items < 40 || frame_no < 4) begin
      w = ($urandom_range(3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
      h = ($urandom_range(3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 5);
      case (frame_no % 4)
        0: set_pace(0, 0);
        1: set_pace(65, 0);
        2: set_pace(0, 65);
        default: set_pace(13, 13);
      endcase
      set_frame(w, h);
      if (frame_no == 2) hold_left = 40;
      send_frame(count);
      rnd_items += count;
      frame_no++;
    end

    drain();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: filelist.f
sv/mf3_pkg.sv
sv/mf3_ram.sv
sv/mf3_median9.sv
sv/median_filter_3x3_unit.sv
bench/tb.sv
